FILE: rtl/kas_pkg.sv
`default_nettype none

package kas_pkg;

    localparam int ONE_Q     = 65536;
    localparam int DIV_STEPS = 18;

    localparam logic [2:0] MODE_LINEAR  = 3'd1;
    localparam logic [2:0] MODE_CUBIC   = 3'd2;
    localparam logic [2:0] MODE_QLINEAR = 3'd3;
    localparam logic [2:0] MODE_QCUBIC  = 3'd4;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_KEYS  = 2'd1;
    localparam logic [1:0] REG_COMPS = 2'd2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [5:0]         key_index;
        logic [1:0]         component;
        logic [30:0]        stamp;
        logic signed [31:0] key_value;
        logic signed [31:0] tangent_in;
        logic signed [31:0] tangent_out;
        logic [30:0]        progress;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic signed [31:0] value_w;
        logic [30:0]        duration;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/keyframe_animation_sampler_top.sv
`default_nettype none

// Keyframe sampler for one animation channel of up to four Q16.16 components. A write beat
// stores one component of one key. A sample beat runs a sequencer around one shared 33x33
// multiplier, an 18-step restoring divider and a 32-step square root unit, so the block takes
// no new beat until the sample has been handed to the output register. A sample first scales
// the time, then runs a binary search over the key stamps (the stamp memory read sits in each
// probe), fetches the neighbours, forms the ratio with the divider and forms its powers. Each
// component then takes a step, linear or cubic pass, chosen by the mode; the quaternion modes
// then add the sum of squares, the square root and four divides. The key stores are not cleared
// after reset and need no clearing pass.
module keyframe_animation_sampler_top
    import kas_pkg::*;
#(
    parameter int MAX_KEYS   = 64,
    parameter int COMPONENTS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW    = $clog2(MAX_KEYS);
    localparam int KW    = $clog2(MAX_KEYS + 1);
    localparam int SLOTS = MAX_KEYS * COMPONENTS;
    localparam int SW    = $clog2(SLOTS);

    localparam logic [4:0] S_IDLE  = 5'd0,  S_TIME  = 5'd1,  S_TSAT  = 5'd2,  S_SRCH  = 5'd3;
    localparam logic [4:0] S_SCMP  = 5'd4,  S_RDL   = 5'd5,  S_RLO   = 5'd6,  S_RHI   = 5'd7;
    localparam logic [4:0] S_GAP   = 5'd8,  S_RAT   = 5'd9,  S_RDIV  = 5'd10, S_T2    = 5'd11;
    localparam logic [4:0] S_T2W   = 5'd12, S_T3    = 5'd13, S_T3W   = 5'd14, S_CRD   = 5'd15;
    localparam logic [4:0] S_CSEL  = 5'd16, S_LMUL  = 5'd17, S_LACC  = 5'd18, S_M0    = 5'd19;
    localparam logic [4:0] S_M0W   = 5'd20, S_M1W   = 5'd21, S_HMUL  = 5'd22, S_HACC  = 5'd23;
    localparam logic [4:0] S_HFIN  = 5'd24, S_CST   = 5'd25, S_QMUL  = 5'd26, S_QACC  = 5'd27;
    localparam logic [4:0] S_QRT   = 5'd28, S_QDIV  = 5'd29, S_QDIVW = 5'd30, S_DONE  = 5'd31;

    function automatic logic signed [65:0] rnd16(input logic signed [65:0] x);
        rnd16 = (x + 66'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
        else if (x < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = x[31:0];
    endfunction

    // Configuration registers.
    logic [2:0] mode_reg;
    logic [6:0] keys_reg;
    logic [2:0] comps_reg;

    // Key stores.
    logic [30:0]        stamp_mem [MAX_KEYS];
    logic signed [31:0] val_mem   [SLOTS];
    logic signed [31:0] tin_mem   [SLOTS];
    logic signed [31:0] tout_mem  [SLOTS];
    logic [30:0]        stamp_rd;
    logic signed [31:0] p0_rd, p1_rd, tin_rd, tout_rd;

    logic [4:0]         state_reg;
    logic [30:0]        longest_reg, progress_reg, time_reg, stamp_lo_reg;
    logic [KW-1:0]      lo_reg, hi_reg, mid_reg;
    logic [AW-1:0]      lower_reg, upper_reg;
    logic signed [31:0] gap_reg, num_reg;
    logic [16:0]        ratio_reg, t2_reg, t3_reg;
    logic [1:0]         c_reg, k_reg;
    logic [2:0]         hk_reg;
    logic signed [47:0] m0_reg, m1_reg;
    logic signed [63:0] acc_reg, v_reg;
    logic signed [31:0] res_reg [4];
    logic [64:0]        sum_reg;
    logic [63:0]        sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [32:0]        norm_reg;
    logic signed [65:0] prod_reg;
    out_item_t          m_data_reg;
    logic               m_valid_reg;

    // Shared divider.
    logic               div_busy_reg;
    logic [33:0]        div_rem_reg;
    logic [17:0]        div_dq_reg;
    logic [32:0]        div_dsr_reg;
    logic [4:0]         div_cnt_reg;
    logic               div_start;
    logic [47:0]        div_dvd_in;
    logic [32:0]        div_dsr_in;
    logic [33:0]        div_trial;

    logic               s_accept, wr_ok;
    logic [KW-1:0]      n_c, lom1;
    logic [KW:0]        mid_sum;
    logic [KW-1:0]      mid_c;
    logic [AW-1:0]      lower_c, upper_c, stamp_raddr;
    logic [2:0]         comps_c;
    logic [SW-1:0]      lo_slot, hi_slot, wr_slot;
    logic [AW-1:0]      wr_key;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_rnd, acc_rnd;
    logic signed [19:0] ts, t2s, t3s, h00, h10, h01, h11;
    logic signed [63:0] hterm;
    logic [31:0]        qabs;
    logic [64:0]        sum_next;
    logic [63:0]        sq_trial;
    logic [45:0]        tprod;
    logic               rat_div;
    logic signed [31:0] qres;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign pready   = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_MODE:  prdata = {29'd0, mode_reg};
            REG_KEYS:  prdata = {25'd0, keys_reg};
            REG_COMPS: prdata = {29'd0, comps_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // Effective key and component counts.
    always_comb begin
        if (keys_reg == 7'd0)
            n_c = KW'(1);
        else if (32'(keys_reg) > MAX_KEYS)
            n_c = KW'(MAX_KEYS);
        else
            n_c = KW'(keys_reg);
        if (comps_reg == 3'd0)
            comps_c = 3'd1;
        else if (32'(comps_reg) > COMPONENTS)
            comps_c = 3'(COMPONENTS);
        else
            comps_c = comps_reg;
    end

    always_comb begin
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid_c   = mid_sum[KW:1];
        lom1    = lo_reg - KW'(1);
        lower_c = (lo_reg == '0) ? '0 : lom1[AW-1:0];
        upper_c = (lo_reg >= n_c) ? lom1[AW-1:0] : lo_reg[AW-1:0];
        case (state_reg)
            S_SRCH:  stamp_raddr = mid_c[AW-1:0];
            S_RLO:   stamp_raddr = lower_reg;
            default: stamp_raddr = upper_reg;
        endcase
        lo_slot = SW'(32'(lower_reg) * COMPONENTS + 32'(c_reg));
        hi_slot = SW'(32'(upper_reg) * COMPONENTS + 32'(c_reg));
        wr_slot = SW'(32'(s_data.key_index) * COMPONENTS + 32'(s_data.component));
        wr_key  = AW'(s_data.key_index);
        wr_ok   = (32'(s_data.key_index) < MAX_KEYS) && (32'(s_data.component) < COMPONENTS);
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_data.operation == OP_WRITE && wr_ok) begin
            stamp_mem[wr_key]  <= s_data.stamp;
            val_mem[wr_slot]   <= s_data.key_value;
            tin_mem[wr_slot]   <= s_data.tangent_in;
            tout_mem[wr_slot]  <= s_data.tangent_out;
        end
        stamp_rd <= stamp_mem[stamp_raddr];
        p0_rd    <= val_mem[lo_slot];
        p1_rd    <= val_mem[hi_slot];
        tout_rd  <= tout_mem[lo_slot];
        tin_rd   <= tin_mem[hi_slot];
    end

    // Hermite weights from the ratio and its rounded powers.
    always_comb begin
        ts  = $signed({3'b000, ratio_reg});
        t2s = $signed({3'b000, t2_reg});
        t3s = $signed({3'b000, t3_reg});
        h00 = (t3s <<< 1) - 20'sd3 * t2s + 20'sd65536;
        h10 = t3s - (t2s <<< 1) + ts;
        h01 = 20'sd3 * t2s - (t3s <<< 1);
        h11 = t3s - t2s;
    end

    always_comb begin
        qabs = res_reg[k_reg][31] ? (32'd0 - res_reg[k_reg]) : res_reg[k_reg];
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_TIME: begin
                mul_a = $signed({2'b00, progress_reg});
                mul_b = $signed({2'b00, longest_reg});
            end
            S_T2: begin
                mul_a = $signed({16'd0, ratio_reg});
                mul_b = $signed({16'd0, ratio_reg});
            end
            S_T3: begin
                mul_a = $signed({16'd0, t2_reg});
                mul_b = $signed({16'd0, ratio_reg});
            end
            S_LMUL: begin
                mul_a = $signed({16'd0, ratio_reg});
                mul_b = $signed({p1_rd[31], p1_rd}) - $signed({p0_rd[31], p0_rd});
            end
            S_M0: begin
                mul_a = $signed({gap_reg[31], gap_reg});
                mul_b = $signed({tout_rd[31], tout_rd});
            end
            S_M0W: begin
                mul_a = $signed({gap_reg[31], gap_reg});
                mul_b = $signed({tin_rd[31], tin_rd});
            end
            S_HMUL: begin
                case (hk_reg)
                    3'd0: begin
                        mul_a = $signed({{13{h00[19]}}, h00});
                        mul_b = $signed({p0_rd[31], p0_rd});
                    end
                    3'd1: begin
                        mul_a = $signed({{13{h01[19]}}, h01});
                        mul_b = $signed({p1_rd[31], p1_rd});
                    end
                    3'd2: begin
                        mul_a = $signed({{13{h10[19]}}, h10});
                        mul_b = $signed({m0_reg[47], m0_reg[47:16]});
                    end
                    3'd3: begin
                        mul_a = $signed({{13{h10[19]}}, h10});
                        mul_b = $signed({17'd0, m0_reg[15:0]});
                    end
                    3'd4: begin
                        mul_a = $signed({{13{h11[19]}}, h11});
                        mul_b = $signed({m1_reg[47], m1_reg[47:16]});
                    end
                    default: begin
                        mul_a = $signed({{13{h11[19]}}, h11});
                        mul_b = $signed({17'd0, m1_reg[15:0]});
                    end
                endcase
            end
            S_QMUL: begin
                mul_a = $signed({1'b0, qabs});
                mul_b = $signed({1'b0, qabs});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb begin
        prod_rnd = rnd16(prod_reg);
        acc_rnd  = rnd16({{2{acc_reg[63]}}, acc_reg});
        tprod    = prod_reg[61:16];
        if (hk_reg == 3'd2 || hk_reg == 3'd4)
            hterm = $signed(prod_reg[63:0]) <<< 16;
        else
            hterm = $signed(prod_reg[63:0]);
        sum_next = sum_reg + {1'b0, prod_reg[63:0]};
        sq_trial = sq_res_reg + sq_bit_reg;
        rat_div  = (lower_reg != upper_reg) && (gap_reg > 32'sd0) && (num_reg > 32'sd0)
                   && (num_reg < gap_reg);
        qres     = $signed({15'd0, div_dq_reg[16:0]});
    end

    // The divider is shared by the ratio and the quaternion normalization.
    always_comb begin
        div_start  = (state_reg == S_RAT && rat_div) || (state_reg == S_QDIV);
        if (state_reg == S_QDIV) begin
            div_dvd_in = {qabs, 16'd0} + {16'd0, norm_reg[32:1]};
            div_dsr_in = norm_reg;
        end else begin
            div_dvd_in = {1'b0, num_reg[30:0], 16'd0};
            div_dsr_in = {1'b0, gap_reg};
        end
        div_trial = {div_rem_reg[32:0], div_dq_reg[17]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
        end else if (div_start) begin
            div_busy_reg <= 1'b1;
            div_rem_reg  <= {4'd0, div_dvd_in[47:18]};
            div_dq_reg   <= div_dvd_in[17:0];
            div_dsr_reg  <= div_dsr_in;
            div_cnt_reg  <= 5'(DIV_STEPS);
        end else if (div_busy_reg) begin
            if (div_trial >= {1'b0, div_dsr_reg}) begin
                div_rem_reg <= div_trial - {1'b0, div_dsr_reg};
                div_dq_reg  <= {div_dq_reg[16:0], 1'b1};
            end else begin
                div_rem_reg <= div_trial;
                div_dq_reg  <= {div_dq_reg[16:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg - 5'd1;
            if (div_cnt_reg == 5'd1)
                div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_LINEAR;
            keys_reg    <= 7'd1;
            comps_reg   <= 3'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_MODE:  mode_reg  <= pwdata[2:0];
                REG_KEYS:  keys_reg  <= pwdata[6:0];
                REG_COMPS: comps_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready)
                m_valid_reg <= 1'b0;
            if (state_reg == S_DONE && (!m_valid_reg || m_ready))
                m_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_data_reg.value_x  <= res_reg[0];
            m_data_reg.value_y  <= res_reg[1];
            m_data_reg.value_z  <= res_reg[2];
            m_data_reg.value_w  <= res_reg[3];
            m_data_reg.duration <= longest_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            longest_reg <= '0;
            ratio_reg   <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (s_data.operation == OP_SAMPLE) begin
                            progress_reg <= s_data.progress;
                            for (int i = 0; i < 4; i++)
                                res_reg[i] <= '0;
                            state_reg <= S_TIME;
                        end else if (wr_ok && s_data.stamp > longest_reg) begin
                            longest_reg <= s_data.stamp;
                        end
                    end
                end
                S_TIME: state_reg <= S_TSAT;
                S_TSAT: begin
                    time_reg  <= (|tprod[45:31]) ? 31'h7FFFFFFF : tprod[30:0];
                    lo_reg    <= '0;
                    hi_reg    <= n_c;
                    state_reg <= S_SRCH;
                end
                S_SRCH: begin
                    mid_reg <= mid_c;
                    if (lo_reg < hi_reg)
                        state_reg <= S_SCMP;
                    else
                        state_reg <= S_RDL;
                end
                S_SCMP: begin
                    if (stamp_rd <= time_reg)
                        lo_reg <= mid_reg + KW'(1);
                    else
                        hi_reg <= mid_reg;
                    state_reg <= S_SRCH;
                end
                S_RDL: begin
                    lower_reg <= lower_c;
                    upper_reg <= upper_c;
                    state_reg <= S_RLO;
                end
                S_RLO: state_reg <= S_RHI;
                S_RHI: begin
                    stamp_lo_reg <= stamp_rd;
                    state_reg    <= S_GAP;
                end
                S_GAP: begin
                    gap_reg   <= $signed({1'b0, stamp_rd}) - $signed({1'b0, stamp_lo_reg});
                    num_reg   <= $signed({1'b0, time_reg}) - $signed({1'b0, stamp_lo_reg});
                    state_reg <= S_RAT;
                end
                S_RAT: begin
                    if (rat_div) begin
                        state_reg <= S_RDIV;
                    end else begin
                        // A time past the upper stamp takes the full ratio.
                        if (lower_reg != upper_reg && gap_reg > 32'sd0 && num_reg > 32'sd0)
                            ratio_reg <= 17'(ONE_Q);
                        else
                            ratio_reg <= '0;
                        state_reg <= S_T2;
                    end
                end
                S_RDIV: begin
                    if (!div_busy_reg) begin
                        ratio_reg <= div_dq_reg[16:0];
                        state_reg <= S_T2;
                    end
                end
                S_T2: state_reg <= S_T2W;
                S_T2W: begin
                    t2_reg    <= prod_rnd[16:0];
                    state_reg <= S_T3;
                end
                S_T3: state_reg <= S_T3W;
                S_T3W: begin
                    t3_reg    <= prod_rnd[16:0];
                    c_reg     <= '0;
                    state_reg <= S_CRD;
                end
                S_CRD: state_reg <= S_CSEL;
                S_CSEL: begin
                    if (mode_reg inside {MODE_LINEAR, MODE_QLINEAR}) begin
                        state_reg <= S_LMUL;
                    end else if (mode_reg inside {MODE_CUBIC, MODE_QCUBIC}) begin
                        state_reg <= S_M0;
                    end else begin
                        v_reg     <= 64'(p0_rd);
                        state_reg <= S_CST;
                    end
                end
                S_LMUL: state_reg <= S_LACC;
                S_LACC: begin
                    v_reg     <= 64'(p0_rd) + $signed(prod_rnd[63:0]);
                    state_reg <= S_CST;
                end
                S_M0: state_reg <= S_M0W;
                S_M0W: begin
                    m0_reg    <= prod_rnd[47:0];
                    state_reg <= S_M1W;
                end
                S_M1W: begin
                    m1_reg    <= prod_rnd[47:0];
                    acc_reg   <= '0;
                    hk_reg    <= '0;
                    state_reg <= S_HMUL;
                end
                S_HMUL: state_reg <= S_HACC;
                S_HACC: begin
                    acc_reg <= acc_reg + hterm;
                    if (hk_reg == 3'd5) begin
                        state_reg <= S_HFIN;
                    end else begin
                        hk_reg    <= hk_reg + 3'd1;
                        state_reg <= S_HMUL;
                    end
                end
                S_HFIN: begin
                    v_reg     <= acc_rnd[63:0];
                    state_reg <= S_CST;
                end
                S_CST: begin
                    res_reg[c_reg] <= sat32(v_reg);
                    if ({1'b0, c_reg} == comps_c - 3'd1) begin
                        if (mode_reg inside {MODE_QLINEAR, MODE_QCUBIC}) begin
                            k_reg     <= '0;
                            sum_reg   <= '0;
                            state_reg <= S_QMUL;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else begin
                        c_reg     <= c_reg + 2'd1;
                        state_reg <= S_CRD;
                    end
                end
                S_QMUL: state_reg <= S_QACC;
                S_QACC: begin
                    sum_reg <= sum_next;
                    if (k_reg == 2'd3) begin
                        sq_v_reg   <= sum_next[63:0];
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'd1 << 62;
                        state_reg  <= S_QRT;
                    end else begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_QMUL;
                    end
                end
                S_QRT: begin
                    if (sq_bit_reg != 64'd0) begin
                        if (sq_v_reg >= sq_trial) begin
                            sq_v_reg   <= sq_v_reg - sq_trial;
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                        end else begin
                            sq_res_reg <= sq_res_reg >> 1;
                        end
                        sq_bit_reg <= sq_bit_reg >> 2;
                    end else begin
                        // A sum that overflowed 64 bits takes a norm of 65536.0 in Q16.16.
                        norm_reg <= sum_reg[64] ? {1'b1, 32'd0} : sq_res_reg[32:0];
                        k_reg    <= '0;
                        if (!sum_reg[64] && sq_res_reg == 64'd0)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_QDIV;
                    end
                end
                S_QDIV: state_reg <= S_QDIVW;
                S_QDIVW: begin
                    if (!div_busy_reg) begin
                        res_reg[k_reg] <= res_reg[k_reg][31] ? -qres : qres;
                        if (k_reg == 2'd3) begin
                            state_reg <= S_DONE;
                        end else begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= S_QDIV;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.operation == OP_WRITE && !m_valid) |=> !m_valid)
        else $error("write beat produced a result");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy_reg |-> (div_rem_reg < {1'b0, div_dsr_reg}))
        else $error("divider remainder not below divisor");

    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ratio_reg <= 17'(ONE_Q))
        else $error("ratio above one");

    a_search_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCMP) |-> (lo_reg <= mid_reg && mid_reg < hi_reg))
        else $error("search probe outside its interval");

endmodule

`default_nettype wire
